// File: src/sdmu_pkg.sv
// sdmu_pkg: types and constants shared by the sh4 data move unit
// item kinds, result status codes, access sizes, opcode groups and
// the structs passed between the register file, execute stage and top level
package sdmu_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned REG_AW  = 4;
  localparam logic [REG_AW-1:0] REG_R0 = 4'd0;

  typedef enum logic [1:0] {
    KIND_INSN     = 2'd0,
    KIND_LOAD_RET = 2'd1,
    KIND_REG_RD   = 2'd2,
    KIND_REG_WR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_LOAD_PEND = 2'd1,
    ST_BAD_OP    = 2'd2,
    ST_BAD_RET   = 2'd3
  } status_e;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  // opcode groups, top nibble of the instruction word
  localparam logic [3:0] GRP_MISC0     = 4'h0;
  localparam logic [3:0] GRP_MOVL_ST_D = 4'h1;
  localparam logic [3:0] GRP_STORE_IND = 4'h2;
  localparam logic [3:0] GRP_MOVL_LD_D = 4'h5;
  localparam logic [3:0] GRP_LOAD_IND  = 4'h6;
  localparam logic [3:0] GRP_DISP_R0   = 4'h8;
  localparam logic [3:0] GRP_MOVW_PC   = 4'h9;
  localparam logic [3:0] GRP_GBR       = 4'hC;
  localparam logic [3:0] GRP_MOVL_PC   = 4'hD;
  localparam logic [3:0] GRP_MOV_IMM   = 4'hE;

  // sub-function codes
  localparam logic [7:0] FN8_MOVT    = 8'h29;
  localparam logic [3:0] FN_XTRCT    = 4'hD;
  localparam logic [3:0] FN_MOV_RR   = 4'h3;
  localparam logic [3:0] FN_SWAP_B   = 4'h8;
  localparam logic [3:0] FN_SWAP_W   = 4'h9;
  localparam logic [3:0] FN_MOVA     = 4'h7;

  typedef struct packed {
    kind_e            kind;
    logic [15:0]      opcode;
    logic [XLEN-1:0]  pc_value;
    logic             t_flag;
    logic [XLEN-1:0]  gbr_value;
    logic [XLEN-1:0]  data_in;
    logic [REG_AW-1:0] reg_index;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic             mem_request;
    logic             mem_is_write;
    logic [1:0]       mem_size;
    logic [XLEN-1:0]  mem_address;
    logic [XLEN-1:0]  mem_write_data;
    logic [XLEN-1:0]  next_pc;
    logic [XLEN-1:0]  reg_value;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } wb_t;

  typedef struct packed {
    logic              valid;
    logic [REG_AW-1:0] dest;
    logic [1:0]        size;
  } pend_t;

  typedef struct packed {
    logic [XLEN-1:0] r0;
    logic [XLEN-1:0] rn;
    logic [XLEN-1:0] rm;
  } operands_t;

endpackage

// File: src/sdmu_in_if.sv
// sdmu_in_if: input item channel of the sh4 data move unit
// valid/ready handshake plus the item payload; no dependencies
interface sdmu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] opcode;
  logic [31:0] pc_value;
  logic        t_flag;
  logic [31:0] gbr_value;
  logic [31:0] data_in;
  logic [3:0]  reg_index;

  modport source (
    output valid, kind, opcode, pc_value, t_flag, gbr_value, data_in, reg_index,
    input  ready
  );
  modport sink (
    input  valid, kind, opcode, pc_value, t_flag, gbr_value, data_in, reg_index,
    output ready
  );
endinterface

// File: src/sdmu_out_if.sv
// sdmu_out_if: result channel of the sh4 data move unit
// valid/ready handshake plus the result payload; no dependencies
interface sdmu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        mem_request;
  logic        mem_is_write;
  logic [1:0]  mem_size;
  logic [31:0] mem_address;
  logic [31:0] mem_write_data;
  logic [31:0] next_pc;
  logic [31:0] reg_value;

  modport source (
    output valid, status, mem_request, mem_is_write, mem_size, mem_address,
           mem_write_data, next_pc, reg_value,
    input  ready
  );
  modport sink (
    input  valid, status, mem_request, mem_is_write, mem_size, mem_address,
           mem_write_data, next_pc, reg_value,
    output ready
  );
endinterface

// File: src/sdmu_regfile.sv
// sdmu_regfile: sixteen general registers in two mirrored synchronous banks
// bank a serves the rn and rm reads, bank b serves r0; one write port
// depends on sdmu_pkg
module sdmu_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [sdmu_pkg::REG_AW-1:0]    rd_addr_n_i,
  input  logic [sdmu_pkg::REG_AW-1:0]    rd_addr_m_i,
  input  sdmu_pkg::wb_t                  wb_i,
  output logic [sdmu_pkg::XLEN-1:0]      rd_n_o,
  output logic [sdmu_pkg::XLEN-1:0]      rd_m_o,
  output logic [sdmu_pkg::XLEN-1:0]      rd_0_o
);

  localparam int unsigned NREGS = 2 ** sdmu_pkg::REG_AW;

  logic [sdmu_pkg::XLEN-1:0] bank_a_q [NREGS];
  logic [sdmu_pkg::XLEN-1:0] bank_b_q [NREGS];
  logic [NREGS-1:0]          written_q;
  logic [sdmu_pkg::XLEN-1:0] rd_n_q;
  logic [sdmu_pkg::XLEN-1:0] rd_m_q;
  logic [sdmu_pkg::XLEN-1:0] rd_0_q;

  // entries read as zero until first written after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wb_i.en) begin
      written_q[wb_i.addr] <= 1'b1;
    end
  end

  // write port, both banks kept identical
  always_ff @(posedge clk_i) begin
    if (wb_i.en) begin
      bank_a_q[wb_i.addr] <= wb_i.data;
      bank_b_q[wb_i.addr] <= wb_i.data;
    end
  end

  // registered reads, held while no new item enters
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_n_q <= written_q[rd_addr_n_i] ? bank_a_q[rd_addr_n_i] : '0;
      rd_m_q <= written_q[rd_addr_m_i] ? bank_a_q[rd_addr_m_i] : '0;
      rd_0_q <= written_q[sdmu_pkg::REG_R0] ? bank_b_q[sdmu_pkg::REG_R0] : '0;
    end
  end

  assign rd_n_o = rd_n_q;
  assign rd_m_o = rd_m_q;
  assign rd_0_o = rd_0_q;

endmodule

// File: src/sdmu_exec.sv
// sdmu_exec: decode and execute of one item from its register operands
// gives the result, the register write-back and the next pending-load state
// depends on sdmu_pkg
module sdmu_exec (
  input  sdmu_pkg::item_t      item_i,
  input  sdmu_pkg::operands_t  ops_i,
  input  sdmu_pkg::pend_t      pend_i,
  output sdmu_pkg::result_t    res_o,
  output sdmu_pkg::wb_t        wb_o,
  output sdmu_pkg::pend_t      pend_o
);

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] mask;
    case (sz)
      sdmu_pkg::SZ_BYTE: mask = 32'h0000_00FF;
      sdmu_pkg::SZ_WORD: mask = 32'h0000_FFFF;
      default:           mask = 32'hFFFF_FFFF;
    endcase
    return mask;
  endfunction

  function automatic logic [31:0] sext_size(input logic [31:0] v, input logic [1:0] sz);
    logic [31:0] r;
    case (sz)
      sdmu_pkg::SZ_BYTE: r = {{24{v[7]}}, v[7:0]};
      sdmu_pkg::SZ_WORD: r = {{16{v[15]}}, v[15:0]};
      default:           r = v;
    endcase
    return r;
  endfunction

  logic [3:0]  grp;
  logic [3:0]  n;
  logic [3:0]  m;
  logic [3:0]  lo;
  logic [7:0]  d8;
  logic [31:0] r0;
  logic [31:0] rn;
  logic [31:0] rm;
  logic [31:0] pc_al;
  logic [31:0] base;
  logic [31:0] off;
  logic [31:0] addr;
  logic [31:0] sdata;
  logic [1:0]  sz;
  logic [3:0]  dest;
  logic        ok;
  logic        ld;
  logic        st;
  logic        we;
  logic        we_from_addr;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  // instruction decode and address generation
  always_comb begin
    grp   = item_i.opcode[15:12];
    n     = item_i.opcode[11:8];
    m     = item_i.opcode[7:4];
    lo    = item_i.opcode[3:0];
    d8    = item_i.opcode[7:0];
    r0    = ops_i.r0;
    rn    = ops_i.rn;
    rm    = ops_i.rm;
    pc_al = {item_i.pc_value[31:2], 2'b00};

    ok           = 1'b1;
    ld           = 1'b0;
    st           = 1'b0;
    sz           = sdmu_pkg::SZ_LONG;
    base         = '0;
    off          = '0;
    sdata        = '0;
    dest         = n;
    we           = 1'b0;
    we_from_addr = 1'b0;
    waddr        = n;
    wdata        = '0;

    case (grp)
      sdmu_pkg::GRP_MISC0: begin
        if (lo inside {[4'h4:4'h6]}) begin
          st = 1'b1; base = r0; off = rn; sz = lo[1:0]; sdata = rm;
        end else if (lo inside {[4'hC:4'hE]}) begin
          ld = 1'b1; base = r0; off = rm; sz = lo[1:0];
        end else if (d8 == sdmu_pkg::FN8_MOVT) begin
          we = 1'b1; wdata = {31'b0, item_i.t_flag};
        end else begin
          ok = 1'b0;
        end
      end
      sdmu_pkg::GRP_MOVL_ST_D: begin
        st = 1'b1; base = rn; off = {26'b0, lo, 2'b00}; sdata = rm;
      end
      sdmu_pkg::GRP_STORE_IND: begin
        if (lo inside {[4'h0:4'h2]}) begin
          st = 1'b1; base = rn; sz = lo[1:0]; sdata = rm;
        end else if (lo inside {[4'h4:4'h6]}) begin
          // pre-decrement: store data is rm before the update
          st = 1'b1; base = rn; sz = lo[1:0]; off = {32{1'b1}} << lo[1:0];
          sdata = rm; we = 1'b1; we_from_addr = 1'b1;
        end else if (lo == sdmu_pkg::FN_XTRCT) begin
          we = 1'b1; wdata = {rm[15:0], rn[31:16]};
        end else begin
          ok = 1'b0;
        end
      end
      sdmu_pkg::GRP_MOVL_LD_D: begin
        ld = 1'b1; base = rm; off = {26'b0, lo, 2'b00};
      end
      sdmu_pkg::GRP_LOAD_IND: begin
        if (lo inside {[4'h0:4'h2]}) begin
          ld = 1'b1; base = rm; sz = lo[1:0];
        end else if (lo == sdmu_pkg::FN_MOV_RR) begin
          we = 1'b1; wdata = rm;
        end else if (lo inside {[4'h4:4'h6]}) begin
          // post-increment, skipped when the load lands in rm itself
          ld = 1'b1; base = rm; sz = lo[1:0];
          we = (n != m); waddr = m; wdata = rm + (32'd1 << lo[1:0]);
        end else if (lo == sdmu_pkg::FN_SWAP_B) begin
          we = 1'b1; wdata = {rm[31:16], rm[7:0], rm[15:8]};
        end else if (lo == sdmu_pkg::FN_SWAP_W) begin
          we = 1'b1; wdata = {rm[15:0], rm[31:16]};
        end else begin
          ok = 1'b0;
        end
      end
      sdmu_pkg::GRP_DISP_R0: begin
        if (n inside {[4'h0:4'h1]}) begin
          st = 1'b1; base = rm; off = {28'b0, lo} << n[0];
          sz = {1'b0, n[0]}; sdata = r0;
        end else if (n inside {[4'h4:4'h5]}) begin
          ld = 1'b1; base = rm; off = {28'b0, lo} << n[0];
          sz = {1'b0, n[0]}; dest = sdmu_pkg::REG_R0;
        end else begin
          ok = 1'b0;
        end
      end
      sdmu_pkg::GRP_MOVW_PC: begin
        ld = 1'b1; base = item_i.pc_value; off = {23'b0, d8, 1'b0} + 32'd4;
        sz = sdmu_pkg::SZ_WORD;
      end
      sdmu_pkg::GRP_GBR: begin
        if (n inside {[4'h0:4'h2]}) begin
          st = 1'b1; base = item_i.gbr_value; off = {24'b0, d8} << n[1:0];
          sz = n[1:0]; sdata = r0;
        end else if (n inside {[4'h4:4'h6]}) begin
          ld = 1'b1; base = item_i.gbr_value; off = {24'b0, d8} << n[1:0];
          sz = n[1:0]; dest = sdmu_pkg::REG_R0;
        end else if (n == sdmu_pkg::FN_MOVA) begin
          base = pc_al; off = {22'b0, d8, 2'b00} + 32'd4;
          we = 1'b1; we_from_addr = 1'b1; waddr = sdmu_pkg::REG_R0;
        end else begin
          ok = 1'b0;
        end
      end
      sdmu_pkg::GRP_MOVL_PC: begin
        ld = 1'b1; base = pc_al; off = {22'b0, d8, 2'b00} + 32'd4;
      end
      sdmu_pkg::GRP_MOV_IMM: begin
        we = 1'b1; wdata = {{24{d8[7]}}, d8};
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    addr = base + off;
    if (we_from_addr) begin
      wdata = addr;
    end
  end

  // result, write-back and pending state per item kind
  always_comb begin
    res_o  = '0;
    res_o.status = sdmu_pkg::ST_DONE;
    wb_o   = '0;
    pend_o = pend_i;

    case (item_i.kind)
      sdmu_pkg::KIND_INSN: begin
        if (ok) begin
          res_o.status         = ld ? sdmu_pkg::ST_LOAD_PEND : sdmu_pkg::ST_DONE;
          res_o.mem_request    = ld | st;
          res_o.mem_is_write   = st;
          res_o.mem_size       = (ld | st) ? sz : 2'd0;
          res_o.mem_address    = (ld | st) ? addr : '0;
          res_o.mem_write_data = st ? (sdata & size_mask(sz)) : '0;
          res_o.next_pc        = item_i.pc_value + 32'd2;
          wb_o.en   = we;
          wb_o.addr = waddr;
          wb_o.data = wdata;
          if (ld) begin
            pend_o.valid = 1'b1;
            pend_o.dest  = dest;
            pend_o.size  = sz;
          end
        end else begin
          res_o.status  = sdmu_pkg::ST_BAD_OP;
          res_o.next_pc = item_i.pc_value;
        end
      end
      sdmu_pkg::KIND_LOAD_RET: begin
        if (pend_i.valid) begin
          wb_o.en      = 1'b1;
          wb_o.addr    = pend_i.dest;
          wb_o.data    = sext_size(item_i.data_in, pend_i.size);
          pend_o.valid = 1'b0;
        end else begin
          res_o.status = sdmu_pkg::ST_BAD_RET;
        end
      end
      sdmu_pkg::KIND_REG_RD: begin
        res_o.reg_value = rn;
      end
      default: begin
        wb_o.en   = 1'b1;
        wb_o.addr = item_i.reg_index;
        wb_o.data = item_i.data_in;
      end
    endcase
  end

endmodule

// File: src/sh4_data_move_unit.sv
// sh4_data_move_unit: top level of the sh4 data-transfer execution block
// register read stage, execute with forwarding, pending-load state, output register
// depends on sdmu_pkg, sdmu_in_if, sdmu_out_if, sdmu_regfile, sdmu_exec
//
// usage:
// - in_ch_i carries items: instructions, load returns, register reads and writes
// - out_ch_o carries exactly one result per item, in item order
// - a transfer happens on a rising clock edge with valid and ready both high
// - throughput is one item per cycle while the receiver takes results; the register
//   file is read in the cycle an item is accepted, the item executes in the next and
//   writes back when it leaves the execute stage
// - the register file read and the execute stage register share the accepting edge,
//   and execute feeds the output register, from which the result transfers
// - a result from the previous item written back at the same edge is
//   forwarded into the operands, so dependent items follow back to back
// - when the receiver stalls, the result register holds, the execute stage
//   holds any item it has, with in_ch_i.ready low while it does, until the result is taken
// - reset makes all sixteen registers read as zero and clears the pending load
//   and both valid flags; no clearing pass is needed
module sh4_data_move_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdmu_in_if.sink       in_ch_i,
  sdmu_out_if.source    out_ch_o
);

  sdmu_pkg::item_t      in_item;
  sdmu_pkg::item_t      s1_item_q;
  logic                 s1_valid_q;
  logic                 s1_adv;
  logic                 in_xfer;
  logic [3:0]           rd_addr_n;
  logic [3:0]           s1_addr_n;
  logic [3:0]           s1_addr_m;
  logic [31:0]          rd_n;
  logic [31:0]          rd_m;
  logic [31:0]          rd_0;
  sdmu_pkg::operands_t  ops;
  sdmu_pkg::wb_t        fwd_q;
  sdmu_pkg::wb_t        exec_wb;
  sdmu_pkg::wb_t        wb_commit;
  sdmu_pkg::pend_t      pend_q;
  sdmu_pkg::pend_t      exec_pend;
  sdmu_pkg::result_t    exec_res;
  sdmu_pkg::result_t    out_q;
  logic                 out_valid_q;

  // input payload
  assign in_item.kind      = sdmu_pkg::kind_e'(in_ch_i.kind);
  assign in_item.opcode    = in_ch_i.opcode;
  assign in_item.pc_value  = in_ch_i.pc_value;
  assign in_item.t_flag    = in_ch_i.t_flag;
  assign in_item.gbr_value = in_ch_i.gbr_value;
  assign in_item.data_in   = in_ch_i.data_in;
  assign in_item.reg_index = in_ch_i.reg_index;

  // pipeline flow control
  assign s1_adv        = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer       = in_ch_i.valid && in_ch_i.ready;

  // register file read addresses at accept
  assign rd_addr_n = (in_item.kind == sdmu_pkg::KIND_INSN) ? in_item.opcode[11:8]
                                                           : in_item.reg_index;

  sdmu_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_xfer),
    .rd_addr_n_i (rd_addr_n),
    .rd_addr_m_i (in_item.opcode[7:4]),
    .wb_i        (wb_commit),
    .rd_n_o      (rd_n),
    .rd_m_o      (rd_m),
    .rd_0_o      (rd_0)
  );

  // execute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item;
    end
  end

  // forward the write that landed at the same edge as the read
  assign s1_addr_n = (s1_item_q.kind == sdmu_pkg::KIND_INSN) ? s1_item_q.opcode[11:8]
                                                             : s1_item_q.reg_index;
  assign s1_addr_m = s1_item_q.opcode[7:4];

  assign ops.rn = (fwd_q.en && fwd_q.addr == s1_addr_n) ? fwd_q.data : rd_n;
  assign ops.rm = (fwd_q.en && fwd_q.addr == s1_addr_m) ? fwd_q.data : rd_m;
  assign ops.r0 = (fwd_q.en && fwd_q.addr == sdmu_pkg::REG_R0) ? fwd_q.data : rd_0;

  sdmu_exec u_exec (
    .item_i (s1_item_q),
    .ops_i  (ops),
    .pend_i (pend_q),
    .res_o  (exec_res),
    .wb_o   (exec_wb),
    .pend_o (exec_pend)
  );

  // write back only when the item leaves the execute stage
  always_comb begin
    wb_commit    = exec_wb;
    wb_commit.en = exec_wb.en && s1_adv;
  end

  // bypass register and pending-load state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= '0;
      pend_q <= '0;
    end else begin
      if (in_xfer) begin
        fwd_q <= wb_commit;
      end
      if (s1_adv) begin
        pend_q <= exec_pend;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= exec_res;
    end
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.status         = out_q.status;
  assign out_ch_o.mem_request    = out_q.mem_request;
  assign out_ch_o.mem_is_write   = out_q.mem_is_write;
  assign out_ch_o.mem_size       = out_q.mem_size;
  assign out_ch_o.mem_address    = out_q.mem_address;
  assign out_ch_o.mem_write_data = out_q.mem_write_data;
  assign out_ch_o.next_pc        = out_q.next_pc;
  assign out_ch_o.reg_value      = out_q.reg_value;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_ch_i.ready)
    else $error("input accepted while execute stage is stalled");

  a_load_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && exec_res.status == sdmu_pkg::ST_LOAD_PEND) |=> pend_q.valid)
    else $error("issued load left no pending load");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("result appeared without an item leaving execute");
`endif

endmodule
